// ----- design/faf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, register codes and the quarter-wave sine table for the
// angle flattening block. No dependencies.
package faf_pkg;

  // Harmonics built into the datapath, and how many of them may be applied
  localparam int HARM_SLOTS    = 3;
  localparam int NUM_HARMONICS = 3;

  // Field widths
  localparam int ANGLE_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int TRIG_W   = 16;
  localparam int PROD_W   = GAIN_W + TRIG_W;
  localparam int ACC_W    = 34;
  localparam int OUT_W    = 18;
  localparam int IN_TD_W  = 16;
  localparam int OUT_TD_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int QTAB_LAST  = 256;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS_GAIN_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_GAIN_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COS_GAIN_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_GAIN_2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COS_GAIN_3 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_GAIN_3 = 3'd6;

  // pi in unsigned Q2.30
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef logic [14:0] qtab_t [0:QTAB_LAST];
  typedef logic signed [GAIN_W-1:0] gain_arr_t [HARM_SLOTS];

  // sin(pi*i/512) in Q1.15: Taylor series to 11th order in Q2.30,
  // each term truncated, rounded half up and clamped
  function automatic logic [14:0] quarter_entry(input int unsigned idx);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned q;
    longint          sum;
    x    = (longint'(idx) * PI_Q30) >> 9;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    if (sum < 0) sum = 0;
    q = (longint'(sum) + 64'd16384) >> 15;
    if (q > 64'd32767) q = 64'd32767;
    return q[14:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int i = 0; i <= QTAB_LAST; i++) begin
      t[i] = quarter_entry(i);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // Sine of a binary-angle phase, Q1.15, by quadrant folding of the table
  function automatic logic signed [TRIG_W-1:0] sin_q15(input logic [ANGLE_W-1:0] p);
    logic [14:0] s;
    logic [8:0]  idx;
    logic [8:0]  ridx;
    logic [14:0] t_fwd;
    logic [14:0] t_rev;
    logic signed [TRIG_W-1:0] r;
    s     = {1'b0, p[13:0]} + 15'd32;
    idx   = s[14:6];
    ridx  = 9'd256 - idx;
    t_fwd = QTAB[idx];
    t_rev = QTAB[ridx];
    case (p[15:14])
      2'd0:    r = $signed({1'b0, t_fwd});
      2'd1:    r = $signed({1'b0, t_rev});
      2'd2:    r = -$signed({1'b0, t_fwd});
      default: r = -$signed({1'b0, t_rev});
    endcase
    return r;
  endfunction

  function automatic logic signed [TRIG_W-1:0] cos_q15(input logic [ANGLE_W-1:0] p);
    return sin_q15(p + 16'd16384);
  endfunction

endpackage

// ----- design/fourier_angle_flattening.sv -----
`timescale 1ns / 1ps
// Fourier angle flattening: angle + sum of gain-weighted cos/sin harmonics.
// Depends on faf_pkg (widths, register codes, sine table).
//
//  Channel | Ports                         | Payload
//  --------+-------------------------------+--------------------------------
//  input   | in_tvalid/in_tready/in_tdata  | raw_angle [15:0]
//  result  | out_tvalid/out_tready/out_tdata | corrected_angle [17:0]
//  config  | cfg_wr_en/cfg_index/cfg_wdata | one register per write
//
// One angle per cycle, while the result side does not stall, through six
// register stages: phase multiples, table lookup, gain multiply, two adder
// levels, and round/saturate into the output register. Each stage holds its
// item until the next stage frees, so a stall on the result side neither
// drops nor repeats anything. rst_n (synchronous) clears the valid bits and
// the configuration registers.
module fourier_angle_flattening
  import faf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TD_W-1:0]    in_tdata,   // [15:0] raw_angle
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_TD_W-1:0]   out_tdata,  // [17:0] corrected_angle, rest zero
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [1:0] active_r;
  gain_arr_t  cos_gain_r;
  gain_arr_t  sin_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      for (int k = 0; k < HARM_SLOTS; k++) begin
        cos_gain_r[k] <= '0;
        sin_gain_r[k] <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ACTIVE:     active_r      <= cfg_wdata[1:0];
        REG_COS_GAIN_1: cos_gain_r[0] <= $signed(cfg_wdata);
        REG_SIN_GAIN_1: sin_gain_r[0] <= $signed(cfg_wdata);
        REG_COS_GAIN_2: cos_gain_r[1] <= $signed(cfg_wdata);
        REG_SIN_GAIN_2: sin_gain_r[1] <= $signed(cfg_wdata);
        REG_COS_GAIN_3: cos_gain_r[2] <= $signed(cfg_wdata);
        REG_SIN_GAIN_3: sin_gain_r[2] <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Harmonic k applies when below both the active count and the build limit
  logic [HARM_SLOTS-1:0] harm_on;
  always_comb begin
    for (int k = 0; k < HARM_SLOTS; k++) begin
      harm_on[k] = (k < NUM_HARMONICS) && (2'(k) < active_r);
    end
  end

  // Stage valid bits and per-stage load enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6_r || out_tready;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  // Stage 1: angle and its multiples k*angle, wrapping modulo 2*pi
  logic signed [ANGLE_W-1:0] ang1_r;
  logic [ANGLE_W-1:0]        ph1_r [HARM_SLOTS];
  logic [ANGLE_W-1:0]        ph_nxt [HARM_SLOTS];

  always_comb begin
    ph_nxt[0] = in_tdata;
    ph_nxt[1] = {in_tdata[ANGLE_W-2:0], 1'b0};
    ph_nxt[2] = in_tdata + {in_tdata[ANGLE_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ang1_r <= $signed(in_tdata);
      for (int k = 0; k < HARM_SLOTS; k++) ph1_r[k] <= ph_nxt[k];
    end
  end

  // Stage 2: sine/cosine lookup, zeroed for harmonics not applied
  logic signed [ANGLE_W-1:0] ang2_r;
  logic signed [TRIG_W-1:0]  cos2_r [HARM_SLOTS];
  logic signed [TRIG_W-1:0]  sin2_r [HARM_SLOTS];

  always_ff @(posedge clk) begin
    if (en2) begin
      ang2_r <= ang1_r;
      for (int k = 0; k < HARM_SLOTS; k++) begin
        cos2_r[k] <= harm_on[k] ? cos_q15(ph1_r[k]) : '0;
        sin2_r[k] <= harm_on[k] ? sin_q15(ph1_r[k]) : '0;
      end
    end
  end

  // Stage 3: gain products, Q.15
  logic signed [ANGLE_W-1:0] ang3_r;
  logic signed [PROD_W-1:0]  pc3_r [HARM_SLOTS];
  logic signed [PROD_W-1:0]  ps3_r [HARM_SLOTS];

  always_ff @(posedge clk) begin
    if (en3) begin
      ang3_r <= ang2_r;
      for (int k = 0; k < HARM_SLOTS; k++) begin
        pc3_r[k] <= cos_gain_r[k] * cos2_r[k];
        ps3_r[k] <= sin_gain_r[k] * sin2_r[k];
      end
    end
  end

  // Stage 4: first adder level, angle scaled to Q.15 joins harmonic one
  logic signed [ACC_W-1:0] sa4_r, sb4_r, sc4_r;
  logic signed [ACC_W-1:0] ang_q15;

  assign ang_q15 = ACC_W'($signed({ang3_r, 15'b0}));

  always_ff @(posedge clk) begin
    if (en4) begin
      sa4_r <= ang_q15 + ACC_W'(pc3_r[0]) + ACC_W'(ps3_r[0]);
      sb4_r <= ACC_W'(pc3_r[1]) + ACC_W'(ps3_r[1]);
      sc4_r <= ACC_W'(pc3_r[2]) + ACC_W'(ps3_r[2]);
    end
  end

  // Stage 5: full exact sum
  logic signed [ACC_W-1:0] acc5_r;

  always_ff @(posedge clk) begin
    if (en5) acc5_r <= sa4_r + sb4_r + sc4_r;
  end

  // Stage 6: round half up, saturate to 18 bits
  localparam logic signed [ACC_W-16:0] SAT_HI = (ACC_W-15)'(131071);
  localparam logic signed [ACC_W-16:0] SAT_LO = -(ACC_W-15)'(131072);

  logic signed [ACC_W-1:0]  rsum;
  logic signed [ACC_W-16:0] rq;
  logic signed [OUT_W-1:0]  corr_nxt;
  logic [OUT_W-1:0]         corr_r;

  always_comb begin
    rsum = acc5_r + ACC_W'(16384);
    rq   = rsum[ACC_W-1:15];
    if (rq > SAT_HI)      corr_nxt = SAT_HI[OUT_W-1:0];
    else if (rq < SAT_LO) corr_nxt = SAT_LO[OUT_W-1:0];
    else                  corr_nxt = rq[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en6) corr_r <= corr_nxt;
  end

  assign out_tvalid = v6_r;
  assign out_tdata  = {{(OUT_TD_W-OUT_W){1'b0}}, corr_r};

endmodule
